// ===== hw/rtl/fdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdt_pkg;

	// list and feature table sizes
	localparam int MAX_DELTAS   = 32;
	localparam int NUM_FEATURES = 768;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int PIECE_W = 4;
	localparam int SQ_W    = 6;
	localparam int IDX_W   = 10;
	localparam int EPOS_W  = 5;
	localparam int OLEN_W  = 6;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 6;

	// event decode constants
	localparam int COUNT_MAX = 63;
	localparam int PIECE_MAX = 11;
	localparam int SQ_FLIP   = 56;

	// derived widths
	localparam int LEN_W      = $clog2(MAX_DELTAS + 1);
	localparam int POS_W      = $clog2(MAX_DELTAS);
	localparam int LIST_AW    = POS_W + 1;
	localparam int LIST_DEPTH = 2 ** LIST_AW;
	localparam int FEAT_AW    = $clog2(NUM_FEATURES);
	localparam int CMP_W      = (LEN_W > OLEN_W) ? LEN_W : OLEN_W;

	typedef enum logic [OP_W-1:0] {
		OP_ADD     = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_REFRESH = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_APPENDED  = 3'd0,
		ST_CANCELLED = 3'd1,
		ST_COUNT     = 3'd2,
		ST_REFRESHED = 3'd3,
		ST_CLEARED   = 3'd4,
		ST_READ      = 3'd5,
		ST_FULL      = 3'd6,
		ST_BAD_POS   = 3'd7
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fdt_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fdt_req_if;
	import fdt_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [PIECE_W-1:0] piece_type;
	logic [SQ_W-1:0]    square;
	logic [IDX_W-1:0]   feature_index;
	logic               list_is_add;
	logic               perspective;
	logic [EPOS_W-1:0]  entry_pos;

	modport source (
		output valid, op, piece_type, square, feature_index, list_is_add, perspective,
		       entry_pos,
		input  ready
	);

	modport sink (
		input  valid, op, piece_type, square, feature_index, list_is_add, perspective,
		       entry_pos,
		output ready
	);

endinterface

`default_nettype wire

// ===== hw/rtl/fdt_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fdt_rsp_if;
	import fdt_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  white_index;
	logic [IDX_W-1:0]  black_index;
	logic [IDX_W-1:0]  entry_value;
	logic [OLEN_W-1:0] add_length;
	logic [OLEN_W-1:0] remove_length;
	logic              refresh_seen;

	modport source (
		output valid, status, white_index, black_index, entry_value, add_length,
		       remove_length, refresh_seen,
		input  ready
	);

	modport sink (
		input  valid, status, white_index, black_index, entry_value, add_length,
		       remove_length, refresh_seen,
		output ready
	);

endinterface

`default_nettype wire

// ===== hw/rtl/fdt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/feature_delta_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pending feature change tracker for a neural-net accumulator. Each request is an add or
// remove event (piece type, square), a refresh, a clear of one feature's pending count, or
// a read of one list entry; every request gives exactly one response. The add and remove
// lists (white and mirrored black index per entry) sit in one list memory, the per-feature
// add/remove counts in one count memory, both with one read and one write port. Requests
// are taken one at a time; a request rejected at once (piece, feature index or position
// out of range, unknown op) goes straight to the result stage. A cancel reads the count,
// then scans the opposite list one entry per cycle through the list memory read port, and
// when a match is found reads the last entry and writes it over the match; with the
// opposite list empty it skips the scan. Refresh zeroes the count memory one entry a
// cycle; after reset the same clearing pass runs before the first request is taken. A
// response waiting in the output register does not block the next request from being
// taken.
module feature_delta_tracker (
	input  logic             clk,
	input  logic             arst_n,
	fdt_req_if.sink          req,
	fdt_rsp_if.source        rsp
);
	import fdt_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_CHK,
		S_SCAN,
		S_LAST_RD,
		S_LAST_WR,
		S_LST_RD,
		S_LST_CHK,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [FEAT_AW-1:0]  clr_q;
	logic                clr_reply_q;
	logic [LEN_W-1:0]    add_len_q;
	logic [LEN_W-1:0]    rem_len_q;
	logic                refresh_q;

	// latched request
	logic [OP_W-1:0]     op_q;
	logic [IDX_W-1:0]    wi_q;
	logic [IDX_W-1:0]    bi_q;
	logic [FEAT_AW-1:0]  key_q;
	logic                is_add_q;
	logic                persp_q;
	logic [EPOS_W-1:0]   pos_q;
	logic                show_idx_q;

	// result staging
	status_t             res_status_q;
	logic [IDX_W-1:0]    res_val_q;

	// list scan
	logic [LEN_W-1:0]    scan_q;
	logic                rd_vld_s1;
	logic [POS_W-1:0]    rd_idx_s1;
	logic [POS_W-1:0]    hit_q;

	// response register
	logic                rsp_vld_q;
	logic [STAT_W-1:0]   rsp_status_q;
	logic [IDX_W-1:0]    rsp_white_q;
	logic [IDX_W-1:0]    rsp_black_q;
	logic [IDX_W-1:0]    rsp_val_q;
	logic [OLEN_W-1:0]   rsp_add_len_q;
	logic [OLEN_W-1:0]   rsp_rem_len_q;
	logic                rsp_refresh_q;

	// memory ports
	logic                cnt_we;
	logic [FEAT_AW-1:0]  cnt_waddr;
	logic [2*CNT_W-1:0]  cnt_wdata;
	logic [2*CNT_W-1:0]  cnt_rdata;
	logic                list_we;
	logic [LIST_AW-1:0]  list_waddr;
	logic [2*IDX_W-1:0]  list_wdata;
	logic [LIST_AW-1:0]  list_raddr;
	logic [2*IDX_W-1:0]  list_rdata;

	// decode helpers
	logic                own_sel;
	logic                opp_sel;
	logic                is_addrem;
	logic [CNT_W-1:0]    add_cnt;
	logic [CNT_W-1:0]    rem_cnt;
	logic [CNT_W-1:0]    own_cnt;
	logic [CNT_W-1:0]    opp_cnt;
	logic [LEN_W-1:0]    own_len;
	logic [LEN_W-1:0]    opp_len;
	logic [LEN_W-1:0]    last_idx;
	logic                opp_zero;
	logic                full;
	logic                append;
	logic                scan_issue;
	logic                scan_hit;
	logic                scan_last;
	logic                rsp_load;
	logic                req_addrem;
	logic                req_rd_ok;
	logic [LEN_W-1:0]    req_sel_len;
	logic [CMP_W-1:0]    req_pos_ext;
	logic [CMP_W-1:0]    add_len_ext;
	logic [CMP_W-1:0]    rem_len_ext;

	fdt_ram #(
		.WIDTH (2 * CNT_W),
		.DEPTH (NUM_FEATURES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (key_q),
		.rdata (cnt_rdata)
	);

	fdt_ram #(
		.WIDTH (2 * IDX_W),
		.DEPTH (LIST_DEPTH)
	) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	// own and opposite list selection
	always_comb begin
		is_addrem   = (op_q == OP_ADD) || (op_q == OP_REMOVE);
		own_sel     = (op_q == OP_ADD);
		opp_sel     = ~own_sel;
		add_cnt     = cnt_rdata[2*CNT_W-1:CNT_W];
		rem_cnt     = cnt_rdata[CNT_W-1:0];
		own_cnt     = own_sel ? add_cnt : rem_cnt;
		opp_cnt     = own_sel ? rem_cnt : add_cnt;
		own_len     = own_sel ? add_len_q : rem_len_q;
		opp_len     = own_sel ? rem_len_q : add_len_q;
		last_idx    = opp_len - LEN_W'(1);
		opp_zero    = (opp_cnt == '0);
		full        = (own_len >= LEN_W'(MAX_DELTAS)) || (own_cnt >= CNT_W'(COUNT_MAX));
		append      = is_addrem && opp_zero && !full;
		scan_issue  = (scan_q < opp_len);
		scan_hit    = (list_rdata[2*IDX_W-1:IDX_W] == wi_q);
		scan_last   = (LEN_W'(rd_idx_s1) == last_idx);
		rsp_load    = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);
	end

	// request-side decode
	always_comb begin
		req_addrem  = (req.op == OP_ADD) || (req.op == OP_REMOVE);
		req_sel_len = req.list_is_add ? add_len_q : rem_len_q;
		req_pos_ext = CMP_W'(req.entry_pos);
		req_rd_ok   = (req_pos_ext < CMP_W'(req_sel_len))
		              && (req_pos_ext < CMP_W'(MAX_DELTAS));
		add_len_ext = CMP_W'(add_len_q);
		rem_len_ext = CMP_W'(rem_len_q);
	end

	// count memory writes: clearing pass, count update, single clear
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = key_q;
		cnt_wdata = cnt_rdata;
		if (state_q == S_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else if (state_q == S_CHK) begin
			if (op_q == OP_CLEAR) begin
				cnt_we    = 1'b1;
				cnt_wdata = is_add_q ? {CNT_W'(0), rem_cnt} : {add_cnt, CNT_W'(0)};
			end else if (append) begin
				cnt_we    = 1'b1;
				cnt_wdata = own_sel ? {add_cnt + CNT_W'(1), rem_cnt}
				                    : {add_cnt, rem_cnt + CNT_W'(1)};
			end else if (is_addrem && !opp_zero) begin
				cnt_we    = 1'b1;
				cnt_wdata = own_sel ? {add_cnt, rem_cnt - CNT_W'(1)}
				                    : {add_cnt - CNT_W'(1), rem_cnt};
			end
		end
	end

	// list memory: append, swap-in of last entry, scan and entry reads
	always_comb begin
		list_we    = 1'b0;
		list_waddr = {own_sel, own_len[POS_W-1:0]};
		list_wdata = {wi_q, bi_q};
		list_raddr = {opp_sel, scan_q[POS_W-1:0]};
		if (state_q == S_CHK && append) begin
			list_we = 1'b1;
		end else if (state_q == S_LAST_WR) begin
			list_we    = 1'b1;
			list_waddr = {opp_sel, hit_q};
			list_wdata = list_rdata;
		end
		if (state_q == S_LST_RD) begin
			list_raddr = {is_add_q, POS_W'(pos_q)};
		end else if (state_q == S_LAST_RD) begin
			list_raddr = {opp_sel, last_idx[POS_W-1:0]};
		end
	end

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			clr_reply_q   <= 1'b0;
			add_len_q     <= '0;
			rem_len_q     <= '0;
			refresh_q     <= 1'b0;
			op_q          <= '0;
			wi_q          <= '0;
			bi_q          <= '0;
			key_q         <= '0;
			is_add_q      <= 1'b0;
			persp_q       <= 1'b0;
			pos_q         <= '0;
			show_idx_q    <= 1'b0;
			res_status_q  <= ST_BAD_POS;
			res_val_q     <= '0;
			scan_q        <= '0;
			rd_vld_s1     <= 1'b0;
			rd_idx_s1     <= '0;
			hit_q         <= '0;
			rsp_vld_q     <= 1'b0;
			rsp_status_q  <= '0;
			rsp_white_q   <= '0;
			rsp_black_q   <= '0;
			rsp_val_q     <= '0;
			rsp_add_len_q <= '0;
			rsp_rem_len_q <= '0;
			rsp_refresh_q <= 1'b0;
		end else begin
			// response valid: set on load from the result stage, dropped when taken
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == FEAT_AW'(NUM_FEATURES - 1)) begin
						clr_q       <= '0;
						clr_reply_q <= 1'b0;
						state_q     <= clr_reply_q ? S_DONE : S_IDLE;
					end else begin
						clr_q <= clr_q + FEAT_AW'(1);
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q       <= req.op;
						wi_q       <= {req.piece_type, req.square};
						bi_q       <= {req.piece_type ^ PIECE_W'(1), req.square ^ SQ_W'(SQ_FLIP)};
						key_q      <= req_addrem ? FEAT_AW'({req.piece_type, req.square})
						                         : FEAT_AW'(req.feature_index);
						is_add_q   <= req.list_is_add;
						persp_q    <= req.perspective;
						pos_q      <= req.entry_pos;
						show_idx_q <= req_addrem;
						res_val_q  <= '0;
						priority if (req_addrem) begin
							if (req.piece_type > PIECE_W'(PIECE_MAX)) begin
								res_status_q <= ST_BAD_POS;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_RD;
							end
						end else if (req.op == OP_REFRESH) begin
							add_len_q    <= '0;
							rem_len_q    <= '0;
							refresh_q    <= 1'b1;
							res_status_q <= ST_REFRESHED;
							clr_q        <= '0;
							clr_reply_q  <= 1'b1;
							state_q      <= S_CLEAR;
						end else if (req.op == OP_CLEAR) begin
							if (req.feature_index < IDX_W'(NUM_FEATURES)) begin
								state_q <= S_RD;
							end else begin
								res_status_q <= ST_BAD_POS;
								state_q      <= S_DONE;
							end
						end else if (req.op == OP_READ) begin
							if (req_rd_ok) begin
								state_q <= S_LST_RD;
							end else begin
								res_status_q <= ST_BAD_POS;
								state_q      <= S_DONE;
							end
						end else begin
							res_status_q <= ST_BAD_POS;
							state_q      <= S_DONE;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (op_q == OP_CLEAR) begin
						res_status_q <= ST_CLEARED;
						state_q      <= S_DONE;
					end else if (opp_zero) begin
						if (full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_status_q <= ST_APPENDED;
							if (own_sel) begin
								add_len_q <= add_len_q + LEN_W'(1);
							end else begin
								rem_len_q <= rem_len_q + LEN_W'(1);
							end
						end
						state_q <= S_DONE;
					end else if (opp_len == '0) begin
						res_status_q <= ST_COUNT;
						state_q      <= S_DONE;
					end else begin
						scan_q    <= '0;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one read issued and one entry compared per cycle
					rd_idx_s1 <= scan_q[POS_W-1:0];
					if (scan_issue) begin
						scan_q <= scan_q + LEN_W'(1);
					end
					if (rd_vld_s1 && scan_hit) begin
						hit_q     <= rd_idx_s1;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_LAST_RD;
					end else if (rd_vld_s1 && scan_last) begin
						rd_vld_s1    <= 1'b0;
						res_status_q <= ST_COUNT;
						state_q      <= S_DONE;
					end else begin
						rd_vld_s1 <= scan_issue;
					end
				end
				S_LAST_RD: begin
					state_q <= S_LAST_WR;
				end
				S_LAST_WR: begin
					if (own_sel) begin
						rem_len_q <= rem_len_q - LEN_W'(1);
					end else begin
						add_len_q <= add_len_q - LEN_W'(1);
					end
					res_status_q <= ST_CANCELLED;
					state_q      <= S_DONE;
				end
				S_LST_RD: begin
					state_q <= S_LST_CHK;
				end
				S_LST_CHK: begin
					res_val_q    <= persp_q ? list_rdata[IDX_W-1:0]
					                        : list_rdata[2*IDX_W-1:IDX_W];
					res_status_q <= ST_READ;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_status_q  <= res_status_q;
						rsp_white_q   <= show_idx_q ? wi_q : '0;
						rsp_black_q   <= show_idx_q ? bi_q : '0;
						rsp_val_q     <= res_val_q;
						rsp_add_len_q <= add_len_ext[OLEN_W-1:0];
						rsp_rem_len_q <= rem_len_ext[OLEN_W-1:0];
						rsp_refresh_q <= refresh_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.white_index   = rsp_white_q;
	assign rsp.black_index   = rsp_black_q;
	assign rsp.entry_value   = rsp_val_q;
	assign rsp.add_length    = rsp_add_len_q;
	assign rsp.remove_length = rsp_rem_len_q;
	assign rsp.refresh_seen  = rsp_refresh_q;

	// list lengths stay within the list capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(add_len_q <= LEN_W'(MAX_DELTAS)) && (rem_len_q <= LEN_W'(MAX_DELTAS)))
		else $error("list length above capacity");

	// a taken request always starts work
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("request taken without leaving idle");

	// refresh empties both lists and sets the sticky flag at once
	a_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.op == OP_REFRESH)) |=>
		((add_len_q == '0) && (rem_len_q == '0) && refresh_q && (state_q == S_CLEAR)))
		else $error("refresh did not reset lists");

	// a new response only comes from the result stage
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q == S_DONE))
		else $error("response loaded outside result stage");

endmodule

`default_nettype wire

// ===== tb/sv/feature_delta_tracker_tb.sv =====
`timescale 1ns / 1ps

module feature_delta_tracker_tb;
	import fdt_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1330;
	localparam int CALM_ITEMS   = 150;
	localparam int SETTLE_LEN   = 800;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int POOL_SIZE    = 8;

	// list selectors, matching the list_is_add encoding
	localparam int LIST_REMOVE = 0;
	localparam int LIST_ADD    = 1;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [PIECE_W-1:0] piece_type;
		logic [SQ_W-1:0]    square;
		logic [IDX_W-1:0]   feature_index;
		logic               list_is_add;
		logic               perspective;
		logic [EPOS_W-1:0]  entry_pos;
	} delta_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  white_index;
		logic [IDX_W-1:0]  black_index;
		logic [IDX_W-1:0]  entry_value;
		logic [OLEN_W-1:0] add_length;
		logic [OLEN_W-1:0] remove_length;
		logic              refresh_seen;
	} delta_rsp_t;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} traffic_mode_t;

	class delta_scoreboard;
		logic [IDX_W-1:0] entries [2][2][MAX_DELTAS];   // [list][perspective][position]
		int unsigned      list_len [2];
		logic [CNT_W-1:0] pend_count [2][NUM_FEATURES];
		logic             refresh_flag;
		delta_rsp_t       expected_q [$];
		int               fails;

		function new();
			foreach (entries[l, p, i])
				entries[l][p][i] = '0;
			foreach (pend_count[l, f])
				pend_count[l][f] = '0;
			list_len[LIST_ADD] = 0;
			list_len[LIST_REMOVE] = 0;
			refresh_flag = 1'b0;
			fails = 0;
		endfunction

		function int unsigned list_length(int list_sel);
			return list_len[list_sel];
		endfunction

		function int waiting_count();
			return expected_q.size();
		endfunction

		// advance the tracker state by one request and form its response
		function delta_rsp_t track_request(delta_req_t r);
			delta_rsp_t       e;
			logic [IDX_W-1:0] wi;
			logic [IDX_W-1:0] bi;
			int               own;
			int               opp;
			int               last;
			bit               hit;
			e = '0;
			e.status = ST_BAD_POS;
			case (r.op)
				OP_ADD, OP_REMOVE: begin
					wi = {r.piece_type, r.square};
					bi = {r.piece_type ^ PIECE_W'(1), r.square ^ SQ_W'(SQ_FLIP)};
					e.white_index = wi;
					e.black_index = bi;
					if (r.piece_type <= PIECE_MAX) begin
						own = (r.op == OP_ADD) ? LIST_ADD : LIST_REMOVE;
						opp = 1 - own;
						if (pend_count[opp][wi] == 0) begin
							// nothing to cancel: append unless full or saturated
							if (list_len[own] >= MAX_DELTAS || pend_count[own][wi] >= COUNT_MAX) begin
								e.status = ST_FULL;
							end else begin
								entries[own][0][list_len[own]] = wi;
								entries[own][1][list_len[own]] = bi;
								list_len[own]++;
								pend_count[own][wi]++;
								e.status = ST_APPENDED;
							end
						end else begin
							// cancel: swap first match with last entry and pop
							hit = 1'b0;
							last = int'(list_len[opp]) - 1;
							for (int i = 0; i <= last && !hit; i++) begin
								if (entries[opp][0][i] == wi) begin
									hit = 1'b1;
									entries[opp][0][i] = entries[opp][0][last];
									entries[opp][1][i] = entries[opp][1][last];
									list_len[opp] = last;
								end
							end
							pend_count[opp][wi]--;
							e.status = hit ? ST_CANCELLED : ST_COUNT;
						end
					end
				end
				OP_REFRESH: begin
					foreach (pend_count[l, f])
						pend_count[l][f] = '0;
					list_len[LIST_ADD] = 0;
					list_len[LIST_REMOVE] = 0;
					refresh_flag = 1'b1;
					e.status = ST_REFRESHED;
				end
				OP_CLEAR: begin
					if (r.feature_index < NUM_FEATURES) begin
						pend_count[r.list_is_add][r.feature_index] = '0;
						e.status = ST_CLEARED;
					end
				end
				OP_READ: begin
					if (r.entry_pos < list_len[r.list_is_add]) begin
						e.entry_value = entries[r.list_is_add][r.perspective][r.entry_pos];
						e.status = ST_READ;
					end
				end
				default: begin
				end
			endcase
			e.add_length = OLEN_W'(list_len[LIST_ADD]);
			e.remove_length = OLEN_W'(list_len[LIST_REMOVE]);
			e.refresh_seen = refresh_flag;
			return e;
		endfunction

		function void note_request(delta_req_t r);
			expected_q.insert(expected_q.size(), track_request(r));
		endfunction

		function void compare_field(string label, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
				fails++;
			end
		endfunction

		function void check_response(delta_rsp_t got);
			delta_rsp_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: response with nothing outstanding, code %0d", $time, got.status);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", IDX_W'(want.status), IDX_W'(got.status));
			compare_field("white_index", want.white_index, got.white_index);
			compare_field("black_index", want.black_index, got.black_index);
			compare_field("entry_value", want.entry_value, got.entry_value);
			compare_field("add_length", IDX_W'(want.add_length), IDX_W'(got.add_length));
			compare_field("remove_length", IDX_W'(want.remove_length), IDX_W'(got.remove_length));
			compare_field("refresh_seen", IDX_W'(want.refresh_seen), IDX_W'(got.refresh_seen));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	bit               idling_on;
	int unsigned      cycle_count;
	logic [PIECE_W-1:0] pool_piece [POOL_SIZE];
	logic [SQ_W-1:0]    pool_square [POOL_SIZE];

	delta_scoreboard tracker_sb = new();

	fdt_req_if req_bus ();
	fdt_rsp_if rsp_bus ();

	feature_delta_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// response side backpressure in bursts
	initial begin
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (idling_on && $urandom_range(0, 3) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// response check, fields in struct order
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
			tracker_sb.check_response({rsp_bus.status, rsp_bus.white_index,
				rsp_bus.black_index, rsp_bus.entry_value, rsp_bus.add_length,
				rsp_bus.remove_length, rsp_bus.refresh_seen});
	end

	function automatic delta_req_t make_request(int op, int piece, int sq, int feature,
			int is_add, int persp, int pos);
		delta_req_t r;
		r.op = OP_W'(op);
		r.piece_type = PIECE_W'(piece);
		r.square = SQ_W'(sq);
		r.feature_index = IDX_W'(feature);
		r.list_is_add = 1'(is_add);
		r.perspective = 1'(persp);
		r.entry_pos = EPOS_W'(pos);
		return r;
	endfunction

	// random request; events mostly hit a small pool of features so cancels happen
	function automatic delta_req_t random_request(traffic_mode_t mode);
		delta_req_t  r;
		logic [31:0] raw;
		int          pick;
		int          add_pct;
		int          k;
		int unsigned len;
		raw = $urandom;
		r = raw[$bits(delta_req_t)-1:0];
		pick = $urandom_range(0, 99);
		add_pct = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 15 : 38;
		k = $urandom_range(0, POOL_SIZE - 1);
		if (pick < 80) begin
			r.op = (pick < add_pct) ? OP_ADD : OP_REMOVE;
			if ($urandom_range(0, 19) != 0) begin
				r.piece_type = pool_piece[k];
				r.square = pool_square[k];
			end
		end else if (pick < 92) begin
			r.op = OP_READ;
			len = tracker_sb.list_length(int'(r.list_is_add));
			if (len != 0 && $urandom_range(0, 4) != 0)
				r.entry_pos = EPOS_W'($urandom_range(0, len - 1));
		end else if (pick < 96) begin
			r.op = OP_CLEAR;
			if ($urandom_range(0, 2) != 0)
				r.feature_index = {pool_piece[k], pool_square[k]};
		end else if (pick < 98) begin
			r.op = OP_W'($urandom_range(5, 7));
		end else begin
			r.op = OP_REFRESH;
		end
		return r;
	endfunction

	task automatic send_request(delta_req_t r);
		req_bus.valid <= 1'b1;
		req_bus.op <= r.op;
		req_bus.piece_type <= r.piece_type;
		req_bus.square <= r.square;
		req_bus.feature_index <= r.feature_index;
		req_bus.list_is_add <= r.list_is_add;
		req_bus.perspective <= r.perspective;
		req_bus.entry_pos <= r.entry_pos;
		@(posedge clk);
		while (req_bus.ready !== 1'b1)
			@(posedge clk);
		tracker_sb.note_request(r);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// stop sending until every outstanding response is back
	task automatic hold_until_drained();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (tracker_sb.waiting_count() != 0)
			@(posedge clk);
	endtask

	initial begin
		traffic_mode_t mode;
		int            sent;
		int            episode_len;
		idling_on = 1'b0;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.op <= '0;
		req_bus.piece_type <= '0;
		req_bus.square <= '0;
		req_bus.feature_index <= '0;
		req_bus.list_is_add <= 1'b0;
		req_bus.perspective <= 1'b0;
		req_bus.entry_pos <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// read of an empty list
		send_request(make_request(OP_READ, 0, 0, 0, 1, 0, 0));
		// appends at the index extremes, a third feature, then a duplicate
		send_request(make_request(OP_ADD, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_ADD, PIECE_MAX, 63, 0, 0, 0, 0));
		send_request(make_request(OP_ADD, 5, 20, 0, 0, 0, 0));
		send_request(make_request(OP_ADD, 0, 0, 0, 0, 0, 0));
		// cancel of the first entry, swapped with the last
		send_request(make_request(OP_REMOVE, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_READ, 0, 0, 0, 1, 0, 0));
		send_request(make_request(OP_READ, 0, 0, 0, 1, 1, 0));
		send_request(make_request(OP_READ, 0, 0, 0, 1, 1, 2));
		// read just past the end of the list
		send_request(make_request(OP_READ, 0, 0, 0, 1, 0, 3));
		// remove list append, black read, cancel from the add side
		send_request(make_request(OP_REMOVE, 3, 7, 0, 0, 0, 0));
		send_request(make_request(OP_READ, 0, 0, 0, 0, 1, 0));
		send_request(make_request(OP_ADD, 3, 7, 0, 0, 0, 0));
		// piece out of range on both event kinds
		send_request(make_request(OP_ADD, 12, 1, 0, 0, 0, 0));
		send_request(make_request(OP_REMOVE, 15, 63, 0, 0, 0, 0));
		// cleared count turns a would-be cancel into an append
		send_request(make_request(OP_CLEAR, 0, 0, NUM_FEATURES - 1, 1, 0, 0));
		send_request(make_request(OP_REMOVE, PIECE_MAX, 63, 0, 0, 0, 0));
		send_request(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		// clear out of range
		send_request(make_request(OP_CLEAR, 0, 0, NUM_FEATURES, 1, 0, 0));
		send_request(make_request(OP_CLEAR, 0, 0, 1023, 0, 0, 0));
		// unknown ops
		send_request(make_request(5, 0, 0, 0, 0, 0, 0));
		send_request(make_request(7, 0, 0, 0, 0, 0, 0));
		// refresh, then the lists start over
		send_request(make_request(OP_REFRESH, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_READ, 0, 0, 0, 1, 0, 0));
		send_request(make_request(OP_ADD, 6, 33, 0, 0, 0, 0));
		hold_until_drained();

		// random episodes: fill, drain or mixed traffic over a fresh feature pool
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = traffic_mode_t'($urandom_range(0, 2));
			for (int k = 0; k < POOL_SIZE; k++) begin
				pool_piece[k] = PIECE_W'($urandom_range(0, PIECE_MAX));
				pool_square[k] = SQ_W'($urandom_range(0, 63));
			end
			idling_on = (RANDOM_ITEMS - sent > CALM_ITEMS) && ($urandom_range(0, 3) != 0);
			episode_len = $urandom_range(40, 80);
			for (int i = 0; i < episode_len && sent < RANDOM_ITEMS; i++) begin
				if (RANDOM_ITEMS - sent <= CALM_ITEMS)
					idling_on = 1'b0;
				send_request(random_request(mode));
				sent++;
			end
			if ($urandom_range(0, 3) == 0)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (SETTLE_LEN) @(posedge clk);
		if (tracker_sb.fails == 0 && tracker_sb.waiting_count() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
